FILE: hw/rtl/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants of the text console cursor engine: beat
// payloads, command and action codes, character codes, control bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

    // Screen limits and tab spacing
    localparam int MAX_COLUMNS = 512;
    localparam int MAX_ROWS    = 256;
    localparam int TAB_STOP    = 8;

    localparam int COL_LIM = (MAX_COLUMNS < 512) ? MAX_COLUMNS : 512;
    localparam int ROW_LIM = (MAX_ROWS < 256) ? MAX_ROWS : 256;

    localparam logic [9:0] COLS_RESET = 10'd80;
    localparam logic [8:0] ROWS_RESET = 9'd25;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLUMNS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_ROWS    = 1'd1;

    // Input command codes
    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_DRAW  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Output action codes
    localparam logic [1:0] ACT_DRAW   = 2'd0;
    localparam logic [1:0] ACT_SCROLL = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    // Character codes
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] char_code;
        logic [8:0] cell_column;
        logic [7:0] cell_row;
    } t_tcc_in;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] glyph_code;
        logic [8:0] out_column;
        logic [7:0] out_row;
        logic       last;
    } t_tcc_out;

    // Datapath operation for one sequencer step
    typedef enum logic [1:0] {
        OP_DECODE,
        OP_PRINT,
        OP_NEWLINE
    } t_tcc_op;

    // What the step just taken leaves to do
    typedef enum logic [1:0] {
        PH_PRINT,
        PH_NEWLINE,
        PH_DONE
    } t_tcc_phase;

    typedef struct packed {
        logic    load;
        logic    step;
        t_tcc_op op;
        logic    flush;
    } t_tcc_ctl;

    typedef struct packed {
        logic       step_ok;
        t_tcc_phase next_phase;
    } t_tcc_sts;

endpackage

`default_nettype wire

FILE: hw/rtl/tcc_ctrl.sv
// ----------------------------------------------------------------------------
// tcc_ctrl
// Sequencer of the cursor engine: takes one input beat, then walks the
// decode, print and newline steps of the datapath and ends with a flush.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output tcc_pkg::t_tcc_ctl      o_ctl,
    input  wire tcc_pkg::t_tcc_sts i_sts
);
    import tcc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_PRINT,
        S_NEWLINE,
        S_FLUSH
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_ctl       = '0;
        o_ctl.op    = OP_DECODE;
        o_ctl.load  = i_in_valid && (r_state == S_IDLE);
        n_state     = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_ctl.load) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE, S_PRINT, S_NEWLINE: begin
                unique case (r_state)
                    S_PRINT:   o_ctl.op = OP_PRINT;
                    S_NEWLINE: o_ctl.op = OP_NEWLINE;
                    default:   o_ctl.op = OP_DECODE;
                endcase
                o_ctl.step = i_sts.step_ok;
                if (i_sts.step_ok) begin
                    unique case (i_sts.next_phase)
                        PH_PRINT:   n_state = S_PRINT;
                        PH_NEWLINE: n_state = S_NEWLINE;
                        default:    n_state = S_FLUSH;
                    endcase
                end
            end
            S_FLUSH: begin
                o_ctl.flush = i_sts.step_ok;
                if (i_sts.step_ok) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // An accepted beat always starts with decode
    a_load_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_state == S_DECODE)
        else $error("accepted beat did not enter decode");

    // The pending slot is empty when decode begins, so decode never stalls
    a_decode_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DECODE |-> i_sts.step_ok)
        else $error("decode found a result still pending");

    // A newline step is always the final step of an item
    a_newline_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_NEWLINE && i_sts.step_ok |=> r_state == S_FLUSH)
        else $error("newline step did not end the item");

endmodule

`default_nettype wire

FILE: hw/rtl/tcc_dp.sv
// ----------------------------------------------------------------------------
// tcc_dp
// Datapath of the cursor engine: screen size registers, cursor, step logic,
// a one-entry pending slot that settles the last flag, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire tcc_pkg::t_tcc_in                i_in,
    input  wire tcc_pkg::t_tcc_ctl               i_ctl,
    output tcc_pkg::t_tcc_sts                    o_sts,
    input  wire logic                            i_cfg_valid,
    input  wire logic [tcc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [9:0]                      i_cfg_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output tcc_pkg::t_tcc_out                    o_out
);
    import tcc_pkg::*;

    // Control state
    logic [8:0] r_col;
    logic [7:0] r_row;
    logic [9:0] r_cols;
    logic [8:0] r_rows;
    logic       r_pend_v;
    logic       r_out_v;

    // Payload
    t_tcc_in    r_in;
    t_tcc_out   r_pend;
    t_tcc_out   r_out;
    logic       r_tab;
    logic [7:0] r_glyph;
    logic [9:0] r_stop;

    // Step results
    logic       res_v;
    t_tcc_out   res;
    logic [8:0] n_col;
    logic [7:0] n_row;
    logic       n_tab;
    logic [7:0] n_glyph;
    logic [9:0] n_stop;
    t_tcc_phase next_phase;

    logic [8:0] bs_col;
    logic [7:0] bs_row;
    logic [9:0] x_next;
    logic [8:0] y_next;
    logic       out_free;

    assign out_free          = !r_out_v || i_out_ready;
    assign o_sts.step_ok     = !r_pend_v || out_free;
    assign o_sts.next_phase  = next_phase;
    assign o_out_valid       = r_out_v;
    assign o_out             = r_out;

    assign x_next = {1'b0, r_col} + 10'd1;
    assign y_next = {1'b0, r_row} + 9'd1;

    always_comb begin
        res_v      = 1'b0;
        res        = '0;
        res.action = ACT_DRAW;
        n_col      = r_col;
        n_row      = r_row;
        n_tab      = r_tab;
        n_glyph    = r_glyph;
        n_stop     = r_stop;
        next_phase = PH_DONE;
        bs_col     = r_col;
        bs_row     = r_row;
        unique case (i_ctl.op)
            OP_DECODE: begin
                unique case (r_in.command)
                    CMD_DRAW: begin
                        res_v = ({1'b0, r_in.cell_column} < r_cols) &&
                                ({1'b0, r_in.cell_row} < r_rows);
                        res.glyph_code = r_in.char_code;
                        res.out_column = r_in.cell_column;
                        res.out_row    = r_in.cell_row;
                    end
                    CMD_CLEAR: begin
                        res_v      = 1'b1;
                        res.action = ACT_CLEAR;
                        n_col      = '0;
                        n_row      = '0;
                    end
                    CMD_PUT: begin
                        priority if (r_in.char_code == CH_LF) begin
                            next_phase = PH_NEWLINE;
                        end else if (r_in.char_code == CH_CR) begin
                            n_col = '0;
                        end else if (r_in.char_code == CH_BS) begin
                            // step back, wrapping to the end of the row above
                            if (r_col != '0) begin
                                bs_col = r_col - 9'd1;
                            end else if (r_row != '0) begin
                                bs_row = r_row - 8'd1;
                                bs_col = 9'(r_cols - 10'd1);
                            end
                            n_col = bs_col;
                            n_row = bs_row;
                            res_v = ({1'b0, bs_col} < r_cols) && ({1'b0, bs_row} < r_rows);
                            res.glyph_code = CH_SPACE;
                            res.out_column = bs_col;
                            res.out_row    = bs_row;
                        end else if (r_in.char_code == CH_TAB) begin
                            n_tab      = 1'b1;
                            n_glyph    = CH_SPACE;
                            n_stop     = 10'((({1'b0, r_col} / TAB_STOP) + 10'd1) * TAB_STOP);
                            next_phase = PH_PRINT;
                        end else if (r_in.char_code < CH_SPACE ||
                                     r_in.char_code == CH_DEL) begin
                            next_phase = PH_DONE;
                        end else begin
                            n_tab      = 1'b0;
                            n_glyph    = r_in.char_code;
                            next_phase = PH_PRINT;
                        end
                    end
                    default: next_phase = PH_DONE;
                endcase
            end
            OP_PRINT: begin
                // draw at the cursor, then advance or wrap
                res_v = ({1'b0, r_col} < r_cols) && ({1'b0, r_row} < r_rows);
                res.glyph_code = r_glyph;
                res.out_column = r_col;
                res.out_row    = r_row;
                if (x_next >= r_cols) begin
                    next_phase = PH_NEWLINE;
                end else begin
                    n_col = x_next[8:0];
                    if (r_tab && x_next < r_stop) begin
                        next_phase = PH_PRINT;
                    end
                end
            end
            OP_NEWLINE: begin
                n_col = '0;
                if (y_next >= r_rows) begin
                    res_v = 1'b1;
                    if (r_rows <= 9'd1) begin
                        res.action = ACT_CLEAR;
                        n_row      = '0;
                    end else begin
                        res.action = ACT_SCROLL;
                        n_row      = 8'(r_rows - 9'd1);
                    end
                end else begin
                    n_row = y_next[7:0];
                end
            end
            default: next_phase = PH_DONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_cols   <= COLS_RESET;
            r_rows   <= ROWS_RESET;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            // load the output register from the pending slot, else drop a taken beat
            if (r_pend_v && ((i_ctl.step && res_v) || i_ctl.flush)) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
            if (i_cfg_valid) begin
                // hold the clamped screen size
                unique case (i_cfg_idx)
                    REG_TEXT_COLUMNS: begin
                        if (i_cfg_data == '0) begin
                            r_cols <= 10'd1;
                        end else if (i_cfg_data > 10'(COL_LIM)) begin
                            r_cols <= 10'(COL_LIM);
                        end else begin
                            r_cols <= i_cfg_data;
                        end
                    end
                    REG_TEXT_ROWS: begin
                        if (i_cfg_data[8:0] == '0) begin
                            r_rows <= 9'd1;
                        end else if (i_cfg_data[8:0] > 9'(ROW_LIM)) begin
                            r_rows <= 9'(ROW_LIM);
                        end else begin
                            r_rows <= i_cfg_data[8:0];
                        end
                    end
                    default: ;
                endcase
            end
            if (i_ctl.step) begin
                r_col <= n_col;
                r_row <= n_row;
                if (res_v) begin
                    r_pend_v <= 1'b1;
                end
            end
            if (i_ctl.flush && r_pend_v) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_in <= i_in;
        end
        if (i_ctl.step) begin
            r_tab   <= n_tab;
            r_glyph <= n_glyph;
            r_stop  <= n_stop;
            if (res_v) begin
                r_pend <= res;
                if (r_pend_v) begin
                    r_out <= {r_pend[$bits(t_tcc_out)-1:1], 1'b0};
                end
            end
        end
        if (i_ctl.flush && r_pend_v) begin
            r_out <= {r_pend[$bits(t_tcc_out)-1:1], 1'b1};
        end
    end

    // A clear always homes the cursor
    a_clear_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.step && res_v && res.action == ACT_CLEAR |=> r_col == '0 && r_row == '0)
        else $error("clear left the cursor away from home");

    // A scroll leaves the cursor at column 0 of the bottom row
    a_scroll_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.step && res_v && res.action == ACT_SCROLL
        |=> r_col == '0 && {1'b0, r_row} == $past(r_rows) - 9'd1)
        else $error("scroll left the cursor off the bottom row");

    // Every draw beat names a cell on the screen
    a_draw_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out.action == ACT_DRAW
        |-> {1'b0, r_out.out_column} < r_cols && {1'b0, r_out.out_row} < r_rows)
        else $error("draw beat outside the screen");

    // A flush empties the pending slot
    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.flush |=> !r_pend_v)
        else $error("pending result survived a flush");

endmodule

`default_nettype wire

FILE: hw/rtl/text_console_cursor_engine.sv
// Sequencing: each item passes through the idle accept, one decode step, one step per drawn
//   cell (up to 8 for a tab), a newline step where one is due and one flush step; a new item
//   is accepted only once the last one has been flushed.
// Path: each result goes from the step logic into the pending slot and on to the output
//   register; a step stalls while the pending slot is full and the output register holds a
//   beat that is not taken.
// Reset (synchronous, active low) homes the cursor, sets an 80 x 25 screen, drops pending beats.
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Turns console commands into cell draw, scroll and clear beats while
// keeping a text cursor: newline, carriage return, backspace, tab, wrap.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_engine (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // command channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire tcc_pkg::t_tcc_in               i_in,
    // drawing beat channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output tcc_pkg::t_tcc_out                   o_out,
    // configuration write channel
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [tcc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [9:0]                     i_cfg_data
);
    import tcc_pkg::*;

    t_tcc_ctl ctl;
    t_tcc_sts sts;

    // Screen size writes go straight into the size registers; the port never stalls.
    assign o_cfg_ready = 1'b1;

    // Controller: accept a command beat, sequence the steps, flush the last beat.
    tcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_ctl      (ctl),
        .i_sts      (sts)
    );

    // Datapath: cursor, screen size, step logic. Each result is held in a
    // pending slot until the next result or the flush tells whether it is
    // the last beat of its command, then moves to the output register.
    tcc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

FILE: tb/sv/tb_text_console_cursor_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_console_cursor_engine
// Self-checking bench for the console cursor engine: a directed table of
// commands, then randomized phases under several screen sizes, with every
// drawing beat checked against a cycle-free model of the cursor logic.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_text_console_cursor_engine;

    import tcc_pkg::*;

    // Give up after this many cycles without any beat on any channel
    localparam int QUIET_LIMIT      = 4000;
    // Longest stretch the drawing side refuses beats on purpose
    localparam int HOLD_CYCLES      = 300;
    // Quiet cycles before a register write, covering the longest item
    localparam int SETTLE_CYCLES    = 16;
    // At most this many beats follow from one command
    localparam int BEATS_PER_CMD    = 9;
    // Command code with no meaning; the engine ignores it
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // How a row of the directed table is checked
    typedef enum logic [1:0] {
        CHK_PREDICT,    // expected beats come from the cursor model
        CHK_NONE,       // no beat at all
        CHK_ONE         // exactly the one beat typed into the row
    } t_probe_check;

    typedef struct {
        t_tcc_in      cmd;
        t_probe_check mode;
        t_tcc_out     beat;
    } t_probe;

    // ------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_tcc_in               i_in        = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_tcc_out              o_out;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [9:0]            i_cfg_data  = '0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    text_console_cursor_engine u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Cursor model: its own copy of the screen size and the cursor
    // ------------------------------------------------------------------
    logic [9:0] cfg_cols = COLS_RESET;
    logic [8:0] cfg_rows = ROWS_RESET;
    int         cur_col  = 0;
    int         cur_row  = 0;

    t_tcc_out   fresh_beats[$];   // beats of the command being modeled
    t_tcc_out   beats_due[$];     // beats accepted commands still owe

    int  mismatch_cnt = 0;
    bit  timed_out    = 1'b0;
    bit  calm         = 1'b0;     // no idling on either side
    bit  hold_req     = 1'b0;     // ask the drawing side for one long stall
    int  quiet_cycles = 0;

    // Zero counts act as one, oversize counts clamp to the screen limit
    function automatic int screen_cols();
        int c;
        c = int'(cfg_cols);
        if (c == 0) c = 1;
        if (c > COL_LIM) c = COL_LIM;
        return c;
    endfunction

    function automatic int screen_rows();
        int r;
        r = int'(cfg_rows);
        if (r == 0) r = 1;
        if (r > ROW_LIM) r = ROW_LIM;
        return r;
    endfunction

    function automatic void add_beat(logic [1:0] act, logic [7:0] glyph, int col, int row);
        t_tcc_out b;
        // Drop anything past the per-command cap
        if (fresh_beats.size() >= BEATS_PER_CMD) return;
        b.action     = act;
        b.glyph_code = glyph;
        b.out_column = col[8:0];
        b.out_row    = row[7:0];
        b.last       = 1'b0;
        fresh_beats.push_back(b);
    endfunction

    // Draws off the screen vanish
    function automatic void place_cell(logic [7:0] glyph, int col, int row);
        if (col < screen_cols() && row < screen_rows())
            add_beat(ACT_DRAW, glyph, col, row);
    endfunction

    function automatic void home_clear();
        add_beat(ACT_CLEAR, 8'd0, 0, 0);
        cur_col = 0;
        cur_row = 0;
    endfunction

    // Scroll at the bottom row; with a single row the scroll turns into a clear
    function automatic void line_feed();
        int rows;
        int y;
        rows    = screen_rows();
        y       = cur_row + 1;
        cur_col = 0;
        if (y >= rows) begin
            if (rows <= 1) home_clear();
            else add_beat(ACT_SCROLL, 8'd0, 0, 0);
            y = rows - 1;
        end
        cur_row = y & 'hFF;
    endfunction

    // Draw at the cursor (skipped when the cursor is off screen), then advance or wrap
    function automatic void print_glyph(logic [7:0] glyph);
        int x;
        place_cell(glyph, cur_col, cur_row);
        x = cur_col + 1;
        if (x >= screen_cols()) line_feed();
        else cur_col = x & 'h1FF;
    endfunction

    function automatic void put_at_cursor(logic [7:0] ch);
        int stop;
        case (ch)
            CH_LF: line_feed();
            CH_CR: cur_col = 0;
            CH_BS: begin
                // Step back, wrapping to the end of the row above from column 0
                if (cur_col > 0) begin
                    cur_col = cur_col - 1;
                end else if (cur_row > 0) begin
                    cur_row = cur_row - 1;
                    cur_col = (screen_cols() - 1) & 'h1FF;
                end
                place_cell(CH_SPACE, cur_col, cur_row);
            end
            CH_TAB: begin
                // Fill with spaces to the next stop; a wrap ends the fill early
                stop = (cur_col / TAB_STOP + 1) * TAB_STOP;
                do begin
                    print_glyph(CH_SPACE);
                end while (cur_col != 0 && cur_col < stop);
            end
            default: begin
                if (ch >= CH_SPACE && ch != CH_DEL) print_glyph(ch);
            end
        endcase
    endfunction

    // Model one accepted command into fresh_beats, marking the final beat
    function automatic void console_predict(t_tcc_in cmd);
        fresh_beats.delete();
        case (cmd.command)
            CMD_PUT:   put_at_cursor(cmd.char_code);
            CMD_DRAW:  place_cell(cmd.char_code, cmd.cell_column, cmd.cell_row);
            CMD_CLEAR: home_clear();
            default: ;
        endcase
        if (fresh_beats.size() > 0)
            fresh_beats[fresh_beats.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Drawing side: random stalls, one long hold-off, a calm stretch
    // ------------------------------------------------------------------
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            // Refuse beats long enough for the engine to fill and stall its input
            i_out_ready <= 1'b0;
            hold_left   <= HOLD_CYCLES - 1;
            hold_done   <= 1'b1;
        end else if (calm) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= 8);
        end
    end

    // ------------------------------------------------------------------
    // Beat checker: compare each accepted beat with the oldest one due
    // ------------------------------------------------------------------
    task automatic flag_field(string fld, int want_v, int got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, want_v, got_v);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : beat_check
        t_tcc_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (beats_due.size() == 0) begin
                $display({"%0t: unexpected beat, expected none, ",
                          "actual act=%0d glyph=%0d col=%0d row=%0d last=%0b"},
                         $time, o_out.action, o_out.glyph_code, o_out.out_column,
                         o_out.out_row, o_out.last);
                mismatch_cnt++;
            end else begin
                want = beats_due.pop_front();
                flag_field("action",     want.action,     o_out.action);
                flag_field("glyph_code", want.glyph_code, o_out.glyph_code);
                flag_field("out_column", want.out_column, o_out.out_column);
                flag_field("out_row",    want.out_row,    o_out.out_row);
                flag_field("last",       want.last,       o_out.last);
            end
        end
    end

    // Count cycles with no beat on any channel for the watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Command and register drivers
    // ------------------------------------------------------------------

    // Offer one command, hold it until taken, then model it; an optional gap follows
    task automatic send_cmd(t_tcc_in cmd, t_probe_check mode, t_tcc_out typed);
        int gap;
        i_in       <= cmd;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        console_predict(cmd);
        if (mode == CHK_PREDICT) begin
            foreach (fresh_beats[k]) beats_due.push_back(fresh_beats[k]);
        end else if (mode == CHK_ONE) begin
            beats_due.push_back(typed);
        end
        gap = (!calm && $urandom_range(99) < 8) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Offer one register write and hold it until taken; the caller drops valid
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [9:0] data);
        i_cfg_idx   <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_TEXT_COLUMNS) cfg_cols = data;
        else cfg_rows = data[8:0];
    endtask

    // Wait out every owed beat, then the tail of a command that draws nothing
    task automatic drain_engine();
        while (beats_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random command: mostly printing with real text, some draws, rare clears and junk
    function automatic t_tcc_in random_cmd(bit tab_heavy);
        t_tcc_in c;
        int      roll;
        c.command     = CMD_PUT;
        c.char_code   = 8'($urandom_range(255));
        c.cell_column = 9'($urandom_range(511));
        c.cell_row    = 8'($urandom_range(255));
        roll = $urandom_range(99);
        if (tab_heavy) begin
            // Push the cursor far right and down on a wide screen
            if (roll < 40)      c.char_code = CH_TAB;
            else if (roll < 60) c.char_code = CH_LF;
            else                c.char_code = 8'($urandom_range(32, 126));
            return c;
        end
        if (roll < 15) begin
            c.command = CMD_DRAW;
            if ($urandom_range(1)) begin
                c.cell_column = 9'($urandom_range(screen_cols() - 1));
                c.cell_row    = 8'($urandom_range(screen_rows() - 1));
            end
        end else if (roll < 20) begin
            c.command = CMD_CLEAR;
        end else if (roll < 23) begin
            c.command = CMD_UNUSED;
        end else begin
            roll = $urandom_range(99);
            if (roll < 45)      c.char_code = 8'($urandom_range(32, 255));
            else if (roll < 58) c.char_code = CH_LF;
            else if (roll < 68) c.char_code = CH_TAB;
            else if (roll < 78) c.char_code = CH_BS;
            else if (roll < 83) c.char_code = CH_CR;
        end
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    t_probe probes[$];

    task automatic probe(logic [1:0] cmd, logic [7:0] ch, int col, int row,
                         t_probe_check mode, int o_col = 0, int o_row = 0,
                         logic [1:0] act = ACT_DRAW, logic [7:0] glyph = 8'd0);
        t_probe p;
        p.cmd.command         = cmd;
        p.cmd.char_code       = ch;
        p.cmd.cell_column     = col[8:0];
        p.cmd.cell_row        = row[7:0];
        p.mode                = mode;
        p.beat.action         = act;
        p.beat.glyph_code     = glyph;
        p.beat.out_column     = o_col[8:0];
        p.beat.out_row        = o_row[7:0];
        p.beat.last           = 1'b1;
        probes.push_back(p);
    endtask

    task automatic build_probes();
        // Fresh 80 x 25 screen, cursor home
        probe(CMD_PUT,   8'h41, 0, 0,       CHK_ONE,  0, 0,   ACT_DRAW, 8'h41);
        probe(CMD_DRAW,  8'hFF, 79, 24,     CHK_ONE,  79, 24, ACT_DRAW, 8'hFF);
        probe(CMD_DRAW,  8'h00, 511, 255,   CHK_NONE);
        probe(CMD_DRAW,  8'h78, 80, 0,      CHK_NONE);   // column just off screen
        probe(CMD_DRAW,  8'h79, 0, 25,      CHK_NONE);   // row just off screen
        probe(CMD_UNUSED, 8'hFF, 511, 255,  CHK_NONE);   // unknown command
        probe(CMD_PUT,   CH_CR, 0, 0,       CHK_NONE);
        probe(CMD_PUT,   CH_DEL, 0, 0,      CHK_NONE);
        probe(CMD_PUT,   8'h00, 0, 0,       CHK_NONE);
        probe(CMD_PUT,   8'h1F, 0, 0,       CHK_NONE);
        probe(CMD_PUT,   CH_TAB, 0, 0,      CHK_PREDICT); // full stop of spaces
        probe(CMD_PUT,   8'h42, 0, 0,       CHK_PREDICT);
        probe(CMD_PUT,   CH_TAB, 0, 0,      CHK_PREDICT); // partial stop
        probe(CMD_PUT,   CH_BS, 0, 0,       CHK_PREDICT);
        probe(CMD_PUT,   CH_LF, 0, 0,       CHK_PREDICT);
        probe(CMD_PUT,   CH_BS, 0, 0,       CHK_PREDICT); // back up into the row above
        probe(CMD_PUT,   8'hFF, 0, 0,       CHK_PREDICT); // last column, then wrap
        probe(CMD_CLEAR, 8'h00, 0, 0,       CHK_ONE,  0, 0,   ACT_CLEAR, 8'h00);
        probe(CMD_PUT,   CH_BS, 0, 0,       CHK_ONE,  0, 0,   ACT_DRAW, CH_SPACE);
        probe(CMD_PUT,   8'h80, 0, 0,       CHK_ONE,  0, 0,   ACT_DRAW, 8'h80);
        probe(CMD_DRAW,  8'h00, 0, 0,       CHK_ONE,  0, 0,   ACT_DRAW, 8'h00);
        probe(CMD_PUT,   CH_SPACE, 0, 0,    CHK_PREDICT);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    task automatic run_stimulus();
        int         n_cmds;
        bit         tab_heavy;
        logic [9:0] cols;
        logic [9:0] rows;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        build_probes();
        foreach (probes[k]) send_cmd(probes[k].cmd, probes[k].mode, probes[k].beat);
        i_in_valid <= 1'b0;

        for (int ph = 0; ph < 8; ph++) begin
            tab_heavy = 1'b0;
            calm      = 1'b0;
            n_cmds    = 10;
            case (ph)
                0: begin cols = 10'd1;    rows = 10'd1;   n_cmds = 12; end
                1: begin cols = 10'd0;    rows = 10'd0;   n_cmds = 10; end
                2: begin cols = 10'd1023; rows = 10'd511; n_cmds = 16; tab_heavy = 1'b1; end
                3: begin cols = 10'd8;    rows = 10'd2;   end
                4: begin cols = 10'd5;    rows = 10'd3;   calm = 1'b1; end
                5: begin
                    cols = 10'($urandom_range(1, 24));
                    rows = 10'($urandom_range(1, 12));
                end
                6: begin
                    cols = 10'($urandom_range(0, 1023));
                    rows = 10'($urandom_range(0, 511));
                end
                default: begin
                    cols = COLS_RESET; rows = {1'b0, ROWS_RESET}; n_cmds = 16;
                end
            endcase
            // Resize only with the engine idle
            drain_engine();
            write_reg(REG_TEXT_COLUMNS, cols);
            write_reg(REG_TEXT_ROWS, rows);
            i_cfg_valid <= 1'b0;
            // After the wide phase the cursor sits off the shrunk screen; stall the
            // drawing side here so the engine backs up onto its input
            if (ph == 3) hold_req = 1'b1;
            repeat (n_cmds) send_cmd(random_cmd(tab_heavy), CHK_PREDICT, '0);
            i_in_valid <= 1'b0;
        end
        calm = 1'b0;

        // Let the last beats out, then watch a while for strays
        while (beats_due.size() != 0) @(posedge i_clk);
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        fork
            run_stimulus();
            begin
                wait (quiet_cycles >= QUIET_LIMIT);
                $display("%0t: watchdog, no beat for %0d cycles, %0d beats owed",
                         $time, quiet_cycles, beats_due.size());
                timed_out = 1'b1;
            end
        join_any
        if (!timed_out && mismatch_cnt == 0)
            $display("text_console_cursor_engine verification clean");
        else
            $display("text_console_cursor_engine verification failed");
        $finish;
    end

endmodule

`default_nettype wire
